[sv/mcm_pkg.sv]
// ----------------------------------------------------------------------------
// mcm_pkg
// Shared types and sizes for the median centre-of-mass block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcm_pkg;

	// map geometry and field widths
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_WIDTH  = 64;
	localparam int SIZE_W     = 7;
	localparam int MASS_W     = 16;
	localparam int FRAC_W     = 8;
	localparam int ROW_AW     = $clog2(MAX_HEIGHT);
	localparam int COL_AW     = $clog2(MAX_WIDTH);
	localparam int IDX_W      = (ROW_AW > COL_AW) ? ROW_AW : COL_AW;
	localparam int SUM_W      = 22;
	localparam int TOT_W      = 28;
	localparam int CTR_W      = 15;

	// divider widths: quotient never exceeds 2^FRAC_W
	localparam int DEN_W  = SUM_W + 1;
	localparam int NUM_W  = DEN_W + FRAC_W + 2;
	localparam int QUO_W  = FRAC_W + 1;
	localparam int STEP_W = $clog2(FRAC_W + 1);

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_HEIGHT = 1'b0,
		REG_WIDTH  = 1'b1
	} reg_idx_t;

endpackage

`default_nettype wire

[sv/mcm_ram.sv]
// ----------------------------------------------------------------------------
// mcm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[sv/median_center_of_mass.sv]
// ----------------------------------------------------------------------------
// median_center_of_mass
// Weighted median position of a map of pixel masses, rows and columns.
// ----------------------------------------------------------------------------
// Pixels are fed in raster order, one transfer per start pulse while busy is
// low; each pixel passes through an update state (read, add and write back of
// its column sum). After the last pixel of a map the block searches the row
// sums, then the column sums, one entry per cycle from a memory, and
// interpolates inside the median bucket with a 9-step restoring divider. The
// final pixel therefore holds busy through both searches and both divisions,
// or only through its update for an all-zero map. The result appears on done
// for a single cycle and must be taken then: the block cannot be stalled.
// Writes to map_height or map_width abandon the map in progress.
`default_nettype none

module median_center_of_mass (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration
	input  wire logic                         wr_en,
	input  wire logic [0:0]                   wr_index,
	input  wire logic [mcm_pkg::SIZE_W-1:0]   wr_data,
	// pixel input
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [mcm_pkg::MASS_W-1:0]   mass,
	// result
	output logic                              done,
	output logic      [mcm_pkg::CTR_W-1:0]    center_row,
	output logic      [mcm_pkg::CTR_W-1:0]    center_col,
	output logic      [mcm_pkg::TOT_W-1:0]    mass_sum,
	output logic                              empty_map
);

	import mcm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_SRCH,
		ST_DIV
	} state_t;

	state_t              state_q;
	logic [SIZE_W-1:0]   height_q, width_q;
	logic [SIZE_W-1:0]   h_eff, w_eff;
	logic [COL_AW-1:0]   col_cnt_q;
	logic [ROW_AW-1:0]   row_cnt_q;
	logic [SUM_W-1:0]    row_acc_q;
	logic [TOT_W-1:0]    run_total_q;
	logic [MASS_W-1:0]   mass_s1;
	logic [TOT_W-1:0]    total_q;

	// search and divider state
	logic                phase_col_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [TOT_W-1:0]    cum_q;
	logic [IDX_W-1:0]    cidx_q;
	logic [NUM_W-1:0]    rem_q, dsh_q;
	logic [QUO_W-1:0]    quo_q;
	logic [STEP_W-1:0]   step_q;

	// memory ports
	logic                col_we, row_we;
	logic [COL_AW-1:0]   col_raddr;
	logic [SUM_W-1:0]    col_wdata, col_rdata, row_rdata, row_wdata;

	// combinational helpers
	logic [SUM_W-1:0]    row_acc_nx;
	logic [TOT_W-1:0]    total_nx;
	logic                last_col, last_row;
	logic [SUM_W-1:0]    srch_sum;
	logic [TOT_W-1:0]    cum_nx;
	logic                found;
	logic [DEN_W-1:0]    den, num_a;
	logic                ge;
	logic [QUO_W-1:0]    quo_fin;
	logic [CTR_W-1:0]    center_fin;

	// size register clamp: zero reads as one, above the maximum saturates
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign h_eff = clamp_size(height_q, SIZE_W'(MAX_HEIGHT));
	assign w_eff = clamp_size(width_q, SIZE_W'(MAX_WIDTH));

	// pixel accumulation
	assign row_acc_nx = row_acc_q + SUM_W'(mass_s1);
	assign total_nx   = run_total_q + TOT_W'(mass_s1);
	assign last_col   = (SIZE_W'(col_cnt_q) + SIZE_W'(1)) == w_eff;
	assign last_row   = (SIZE_W'(row_cnt_q) + SIZE_W'(1)) == h_eff;

	assign col_raddr = (state_q == ST_SRCH) ? rd_idx_q[COL_AW-1:0] : col_cnt_q;
	assign col_we    = (state_q == ST_UPD);
	assign col_wdata = (row_cnt_q == '0) ? SUM_W'(mass_s1) : col_rdata + SUM_W'(mass_s1);
	assign row_we    = (state_q == ST_UPD) && last_col;
	assign row_wdata = row_acc_nx;

	// median search: first bucket whose cumulative sum passes half the total
	assign srch_sum = phase_col_q ? col_rdata : row_rdata;
	assign cum_nx   = cum_q + TOT_W'(srch_sum);
	assign found    = {cum_nx, 1'b0} > {1'b0, total_q};
	assign den      = {srch_sum, 1'b0};
	assign num_a    = DEN_W'(total_q - {cum_q[TOT_W-2:0], 1'b0});

	// divider step
	assign ge         = rem_q >= dsh_q;
	assign quo_fin    = {quo_q[QUO_W-2:0], ge};
	assign center_fin = CTR_W'({cidx_q, {FRAC_W{1'b0}}}) + CTR_W'(quo_fin);

	assign busy = (state_q != ST_IDLE);

	mcm_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_col_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (col_cnt_q),
		.wdata (col_wdata),
		.raddr (col_raddr),
		.rdata (col_rdata)
	);

	mcm_ram #(.WIDTH(SUM_W), .DEPTH(MAX_HEIGHT)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_cnt_q),
		.wdata (row_wdata),
		.raddr (rd_idx_q[ROW_AW-1:0]),
		.rdata (row_rdata)
	);

	// control sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			height_q    <= SIZE_W'(MAX_HEIGHT);
			width_q     <= SIZE_W'(MAX_WIDTH);
			col_cnt_q   <= '0;
			row_cnt_q   <= '0;
			row_acc_q   <= '0;
			run_total_q <= '0;
			mass_s1     <= '0;
			total_q     <= '0;
			phase_col_q <= 1'b0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			idx_s1      <= '0;
			cum_q       <= '0;
			cidx_q      <= '0;
			rem_q       <= '0;
			dsh_q       <= '0;
			quo_q       <= '0;
			step_q      <= '0;
			done        <= 1'b0;
			center_row  <= '0;
			center_col  <= '0;
			mass_sum    <= '0;
			empty_map   <= 1'b0;
		end else begin
			done <= 1'b0;

			// configuration write restarts the map
			if (wr_en) begin
				unique case (reg_idx_t'(wr_index))
					REG_HEIGHT: height_q <= wr_data;
					REG_WIDTH:  width_q  <= wr_data;
				endcase
				col_cnt_q   <= '0;
				row_cnt_q   <= '0;
				row_acc_q   <= '0;
				run_total_q <= '0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						mass_s1 <= mass;
						state_q <= ST_UPD;
					end
				end

				ST_UPD: begin
					state_q <= ST_IDLE;
					if (last_col) begin
						col_cnt_q <= '0;
						row_acc_q <= '0;
						if (last_row) begin
							row_cnt_q   <= '0;
							run_total_q <= '0;
							total_q     <= total_nx;
							mass_sum    <= total_nx;
							if (total_nx == '0) begin
								// empty map: centres default to half the size
								empty_map  <= 1'b1;
								center_row <= CTR_W'({h_eff[SIZE_W-1:1], {FRAC_W{1'b0}}});
								center_col <= CTR_W'({w_eff[SIZE_W-1:1], {FRAC_W{1'b0}}});
								done       <= 1'b1;
							end else begin
								empty_map   <= 1'b0;
								phase_col_q <= 1'b0;
								rd_idx_q    <= '0;
								rd_vld_s1   <= 1'b0;
								cum_q       <= '0;
								state_q     <= ST_SRCH;
							end
						end else begin
							row_cnt_q <= row_cnt_q + ROW_AW'(1);
						end
					end else begin
						row_acc_q   <= row_acc_nx;
						col_cnt_q   <= col_cnt_q + COL_AW'(1);
					end
					if (!last_col || !last_row) begin
						run_total_q <= total_nx;
					end
				end

				ST_SRCH: begin
					// one read issued per cycle, its data handled in the next cycle
					rd_idx_q  <= rd_idx_q + IDX_W'(1);
					rd_vld_s1 <= 1'b1;
					idx_s1    <= rd_idx_q;
					if (rd_vld_s1) begin
						if (found) begin
							cidx_q  <= idx_s1;
							rem_q   <= NUM_W'({num_a, {(FRAC_W + 1){1'b0}}}) + NUM_W'(den);
							dsh_q   <= NUM_W'({den, 1'b0, {FRAC_W{1'b0}}});
							quo_q   <= '0;
							step_q  <= '0;
							state_q <= ST_DIV;
						end else begin
							cum_q <= cum_nx;
						end
					end
				end

				ST_DIV: begin
					// restoring division, one quotient bit per cycle
					if (ge) begin
						rem_q <= rem_q - dsh_q;
					end
					quo_q  <= quo_fin;
					dsh_q  <= dsh_q >> 1;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(FRAC_W)) begin
						if (phase_col_q) begin
							center_col <= center_fin;
							done       <= 1'b1;
							state_q    <= ST_IDLE;
						end else begin
							center_row  <= center_fin;
							phase_col_q <= 1'b1;
							rd_idx_q    <= '0;
							rd_vld_s1   <= 1'b0;
							cum_q       <= '0;
							state_q     <= ST_SRCH;
						end
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the median centre-of-mass block.
// ----------------------------------------------------------------------------
// Maps of pixel masses are queued by the stimulus process and fed through the
// start/busy handshake by a clocked driver with random gaps. Each accepted
// pixel goes through a local model of the row/column sums and median search.
// Every finished map leaves one expected result. A clocked monitor compares
// each done strobe with the oldest expectation. Size registers are rewritten
// between phases, only once the block has gone quiet.

module testbench;

	import mcm_pkg::*;

	localparam int CLK_PERIOD  = 4;
	localparam int SETTLE      = 8;       // quiet cycles before a register write
	localparam int TAIL        = 200;     // beyond the longest median search
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_PIXELS = 2000;
	localparam int RANDOM_MAPS   = 60;
	localparam int AREA_CAP      = 512;   // keeps maps short

	typedef enum logic [1:0] {
		OP_PIXEL,
		OP_WRITE,
		OP_QUIESCE
	} op_kind_t;

	typedef enum logic [2:0] {
		MS_RANDOM,
		MS_ZERO,
		MS_SPARSE,
		MS_TINY,
		MS_PEAK
	} mass_style_t;

	typedef enum logic [1:0] {
		GAP_NONE,
		GAP_ANY,
		GAP_RARE
	} gap_mode_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [MASS_W-1:0]   mass;
		reg_idx_t            index;
		logic [SIZE_W-1:0]   value;
		logic [3:0]          gap;
	} pixel_op_t;

	typedef struct packed {
		logic [CTR_W-1:0]    row;
		logic [CTR_W-1:0]    col;
		logic [TOT_W-1:0]    total;
		logic                empty;
	} centre_t;

	// DUT connections
	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                wr_en    = 1'b0;
	reg_idx_t            wr_index = REG_HEIGHT;
	logic [SIZE_W-1:0]   wr_data  = '0;
	logic                start    = 1'b0;
	logic [MASS_W-1:0]   mass     = '0;
	logic                busy;
	logic                done;
	logic [CTR_W-1:0]    center_row;
	logic [CTR_W-1:0]    center_col;
	logic [TOT_W-1:0]    mass_sum;
	logic                empty_map;

	pixel_op_t           pixel_ops[$];
	centre_t             expected_centres[$];
	int unsigned         errors = 0;
	int unsigned         cycles = 0;

	// local model state
	logic [SIZE_W-1:0]   model_height_reg;
	logic [SIZE_W-1:0]   model_width_reg;
	longint unsigned     row_sums [MAX_HEIGHT];
	longint unsigned     col_sums [MAX_WIDTH];
	longint unsigned     row_run;
	longint unsigned     mass_total;
	int unsigned         row_pos;
	int unsigned         col_pos;

	// stimulus-side view of the size registers
	logic [SIZE_W-1:0]   plan_height_reg;
	logic [SIZE_W-1:0]   plan_width_reg;

	// driver state
	logic                armed = 1'b0;
	int unsigned         hold_left = 0;
	int unsigned         settle_left = SETTLE;

	median_center_of_mass dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.start      (start),
		.busy       (busy),
		.mass       (mass),
		.done       (done),
		.center_row (center_row),
		.center_col (center_col),
		.mass_sum   (mass_sum),
		.empty_map  (empty_map)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// zero reads as one, anything above the maximum saturates
	function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] v,
			input int unsigned top);
		if (v == 0)
			return 1;
		if (32'(v) > top)
			return top;
		return 32'(v);
	endfunction

	// first bucket past half the total, then linear interpolation inside it
	function automatic longint unsigned weighted_median(input bit use_cols,
			input int unsigned n, input longint unsigned total);
		longint unsigned cum, lower, upper, bucket, num, den;
		int unsigned     idx;
		bit              found;
		cum   = 0;
		lower = 0;
		upper = 0;
		idx   = 0;
		found = 1'b0;
		for (int unsigned i = 0; i < n && !found; i++) begin
			bucket = use_cols ? col_sums[i] : row_sums[i];
			lower  = cum;
			cum   += bucket;
			if (2 * cum > total) begin
				idx   = i;
				upper = cum;
				found = 1'b1;
			end
		end
		if (!found || upper <= lower)
			return longint'(n) << FRAC_W;
		num = (total - 2 * lower) << FRAC_W;
		den = 2 * (upper - lower);
		// round half up; a fraction of one carries into the index
		return (longint'(idx) << FRAC_W) + (2 * num + den) / (2 * den);
	endfunction

	// abandons the map in progress
	task automatic apply_size_write(input reg_idx_t idx, input logic [SIZE_W-1:0] v);
		if (idx == REG_HEIGHT)
			model_height_reg = v;
		else
			model_width_reg = v;
		row_run    = 0;
		mass_total = 0;
		row_pos    = 0;
		col_pos    = 0;
	endtask

	// one accepted pixel; a completed map leaves an expected centre
	task automatic accumulate_pixel(input logic [MASS_W-1:0] m);
		int unsigned h, w;
		centre_t     c;
		h = clamp_size(model_height_reg, MAX_HEIGHT);
		w = clamp_size(model_width_reg, MAX_WIDTH);
		if (col_pos >= w)
			col_pos = 0;
		if (row_pos >= h)
			row_pos = 0;
		if (row_pos == 0)
			col_sums[col_pos] = 64'(m);
		else
			col_sums[col_pos] += 64'(m);
		row_run    += 64'(m);
		mass_total += 64'(m);
		col_pos++;
		if (col_pos < w)
			return;
		col_pos = 0;
		row_sums[row_pos] = row_run;
		row_run = 0;
		row_pos++;
		if (row_pos < h)
			return;
		c.total = mass_total[TOT_W-1:0];
		c.empty = (mass_total == 0);
		if (c.empty) begin
			c.row = CTR_W'((h / 2) << FRAC_W);
			c.col = CTR_W'((w / 2) << FRAC_W);
		end else begin
			c.row = CTR_W'(weighted_median(1'b0, h, mass_total));
			c.col = CTR_W'(weighted_median(1'b1, w, mass_total));
		end
		expected_centres.insert(expected_centres.size(), c);
		row_run    = 0;
		mass_total = 0;
		row_pos    = 0;
		col_pos    = 0;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// ---- stimulus building ----

	function automatic logic [3:0] draw_gap(input gap_mode_t gm);
		case (gm)
			GAP_NONE: return 4'd0;
			GAP_ANY:  return 4'($urandom_range(0, 12));
			default:  return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(1, 12)) : 4'd0;
		endcase
	endfunction

	function automatic logic [MASS_W-1:0] draw_mass(input mass_style_t ms);
		case (ms)
			MS_ZERO:   return '0;
			MS_SPARSE: return ($urandom_range(0, 15) == 0) ? MASS_W'($urandom) : '0;
			MS_TINY:   return MASS_W'($urandom_range(0, 3));
			MS_PEAK:   return '1;
			default:   return MASS_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] draw_size_value();
		case ($urandom_range(0, 9))
			0:       return 7'd0;
			1:       return 7'd1;
			2:       return 7'd64;
			3:       return 7'd65;
			4:       return 7'd127;
			default: return SIZE_W'($urandom_range(1, 12));
		endcase
	endfunction

	task automatic queue_pixel(input logic [MASS_W-1:0] m, input logic [3:0] gap);
		pixel_op_t op;
		op       = '0;
		op.kind  = OP_PIXEL;
		op.mass  = m;
		op.gap   = gap;
		pixel_ops.insert(pixel_ops.size(), op);
	endtask

	task automatic queue_write(input reg_idx_t idx, input logic [SIZE_W-1:0] v);
		pixel_op_t op;
		op       = '0;
		op.kind  = OP_WRITE;
		op.index = idx;
		op.value = v;
		pixel_ops.insert(pixel_ops.size(), op);
		if (idx == REG_HEIGHT)
			plan_height_reg = v;
		else
			plan_width_reg = v;
	endtask

	// sender holds off until every expected result is back
	task automatic queue_quiesce();
		pixel_op_t op;
		op      = '0;
		op.kind = OP_QUIESCE;
		pixel_ops.insert(pixel_ops.size(), op);
	endtask

	task automatic queue_map(input mass_style_t ms, input gap_mode_t gm,
			input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			queue_pixel(draw_mass(ms), draw_gap(gm));
	endtask

	// ---- driver: start/busy transfers and register writes ----
	always @(posedge clk) begin : drive
		logic      launch;
		logic      write_now;
		pixel_op_t head;
		if (!arst_n) begin
			start       <= 1'b0;
			wr_en       <= 1'b0;
			armed        = 1'b0;
			hold_left    = 0;
			settle_left  = SETTLE;
		end else begin
			launch    = start;
			write_now = 1'b0;
			if (start && !busy) begin
				accumulate_pixel(mass);
				launch = 1'b0;
			end
			if (!launch && pixel_ops.size() != 0) begin
				head = pixel_ops[0];
				if (head.kind == OP_PIXEL) begin
					if (!armed) begin
						hold_left = 32'(head.gap);
						armed     = 1'b1;
					end
					if (hold_left != 0) begin
						hold_left--;
					end else begin
						mass  <= head.mass;
						launch = 1'b1;
						armed  = 1'b0;
						void'(pixel_ops.pop_front());
					end
				end else begin
					// writes and pauses wait for a quiet block
					if (expected_centres.size() != 0 || busy !== 1'b0) begin
						settle_left = SETTLE;
					end else if (settle_left != 0) begin
						settle_left--;
					end else begin
						if (head.kind == OP_WRITE) begin
							write_now = 1'b1;
							wr_index <= head.index;
							wr_data  <= head.value;
							apply_size_write(head.index, head.value);
						end
						settle_left = SETTLE;
						void'(pixel_ops.pop_front());
					end
				end
			end
			start <= launch;
			wr_en <= write_now;
		end
	end

	// ---- monitor: one result per done strobe ----
	always @(posedge clk) begin : observe
		centre_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_centres.size() == 0) begin
				$display("%0t: result with none pending: row %0d col %0d total %0d empty %0d",
					$time, center_row, center_col, mass_sum, empty_map);
				errors++;
			end else begin
				want = expected_centres.pop_front();
				check_field("center_row", 64'(want.row), 64'(center_row));
				check_field("center_col", 64'(want.col), 64'(center_col));
				check_field("mass_sum", 64'(want.total), 64'(mass_sum));
				check_field("empty_map", 64'(want.empty), 64'(empty_map));
			end
		end
	end

	// ---- watchdog ----
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : run
		int unsigned    rand_pixels;
		int unsigned    rand_maps;
		int unsigned    h, w, area, maps, order;
		logic [SIZE_W-1:0] new_h, new_w;
		gap_mode_t      gm;
		mass_style_t    ms;

		// model state after reset
		model_height_reg = 7'd64;
		model_width_reg  = 7'd64;
		plan_height_reg  = 7'd64;
		plan_width_reg   = 7'd64;
		foreach (row_sums[i])
			row_sums[i] = 0;
		foreach (col_sums[i])
			col_sums[i] = 0;
		row_run    = 0;
		mass_total = 0;
		row_pos    = 0;
		col_pos    = 0;

		// height left at its reset value: a tall single-column map
		queue_write(REG_WIDTH, 7'd1);
		queue_map(MS_RANDOM, GAP_ANY, 64);

		// single-pixel maps: zero height reads as one; empty, max and min mass
		queue_write(REG_HEIGHT, 7'd0);
		queue_pixel(16'h0000, 4'd0);
		queue_pixel(16'hFFFF, 4'd0);
		queue_pixel(16'h0001, 4'd3);

		// 2x2: empty map, diagonal peaks, mass only in the last pixel
		queue_write(REG_HEIGHT, 7'd2);
		queue_write(REG_WIDTH, 7'd2);
		queue_map(MS_ZERO, GAP_NONE, 4);
		queue_pixel(16'hFFFF, 4'd0);
		queue_pixel(16'h0000, 4'd0);
		queue_pixel(16'h0000, 4'd0);
		queue_pixel(16'hFFFF, 4'd0);
		queue_map(MS_ZERO, GAP_NONE, 3);
		queue_pixel(16'h0005, 4'd0);
		queue_quiesce();

		// 3x3: a map cut short by a register write, then a full one
		queue_write(REG_HEIGHT, 7'd3);
		queue_write(REG_WIDTH, 7'd3);
		queue_map(MS_RANDOM, GAP_RARE, 5);
		queue_write(REG_WIDTH, 7'd3);
		queue_map(MS_TINY, GAP_NONE, 9);

		// random phases
		rand_pixels = 0;
		rand_maps   = 0;
		while (rand_pixels < RANDOM_PIXELS || rand_maps < RANDOM_MAPS) begin
			new_h = draw_size_value();
			new_w = draw_size_value();
			order = $urandom_range(0, 3);
			h = clamp_size((order != 3) ? new_h : plan_height_reg, MAX_HEIGHT);
			w = clamp_size((order != 2) ? new_w : plan_width_reg, MAX_WIDTH);
			if (h * w > AREA_CAP) begin
				new_w = SIZE_W'($urandom_range(1, 8));
				if (order == 2)
					order = 0;
			end
			case (order)
				0: begin
					queue_write(REG_HEIGHT, new_h);
					queue_write(REG_WIDTH, new_w);
				end
				1: begin
					queue_write(REG_WIDTH, new_w);
					queue_write(REG_HEIGHT, new_h);
				end
				2: queue_write(REG_HEIGHT, new_h);
				default: queue_write(REG_WIDTH, new_w);
			endcase
			area = clamp_size(plan_height_reg, MAX_HEIGHT) * clamp_size(plan_width_reg, MAX_WIDTH);
			gm   = gap_mode_t'($urandom_range(0, 2));
			maps = 1 + $urandom_range(0, 384 / area);
			if (maps > 6)
				maps = 6;
			for (int unsigned k = 0; k < maps; k++) begin
				case ($urandom_range(0, 9))
					0:       ms = MS_ZERO;
					1:       ms = MS_SPARSE;
					2, 3:    ms = MS_TINY;
					4:       ms = MS_PEAK;
					default: ms = MS_RANDOM;
				endcase
				queue_map(ms, gm, area);
				rand_pixels += area;
				rand_maps++;
				if ($urandom_range(0, 7) == 0)
					queue_quiesce();
			end
			// broken map, dropped by the next register write
			if (area > 1 && $urandom_range(0, 3) == 0) begin
				h = $urandom_range(1, area - 1);
				queue_map(MS_RANDOM, gm, h);
				rand_pixels += h;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pixel_ops.size() != 0 || start)
			@(posedge clk);
		while (expected_centres.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
